// ===== hw/rtl/assert_macros.svh =====
// Assertion macros shared by the framebuffer line plotter RTL.
// No dependencies; the checks drop out when SYNTH is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_PROP(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define ASSERT_PROP(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg)
`endif
`endif

// ===== hw/rtl/fbl_pkg.sv =====
// Package of the framebuffer line plotter: display geometry, operation types and helpers.
// No dependencies; fbl_queue, fbl_front, fbl_back and the top level import it.
package fbl_pkg;

	localparam int DISPLAY_WIDTH  = 128;
	localparam int DISPLAY_HEIGHT = 64;
	localparam int PAGE_COUNT     = (DISPLAY_HEIGHT + 7) / 8;
	localparam int STORE_SIZE     = PAGE_COUNT * DISPLAY_WIDTH;
	localparam int ADDR_W         = $clog2(STORE_SIZE);
	localparam int QUEUE_DEPTH    = 4;
	localparam int ERR_W          = 12;

	typedef enum logic [1:0] {
		MODE_PLOT  = 2'd0,
		MODE_LINE  = 2'd1,
		MODE_READ  = 2'd2,
		MODE_CLEAR = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		OP_PIXEL = 2'd0,
		OP_READ  = 2'd1,
		OP_CLEAR = 2'd2
	} op_kind_t;

	typedef struct packed {
		op_kind_t          kind;
		logic              hit;
		logic [ADDR_W-1:0] addr;
		logic [2:0]        bit_sel;
		logic              color;
		logic              last;
	} op_t;

	typedef struct packed {
		logic init_busy;
	} back_status_t;

	typedef enum logic {
		F_IDLE = 1'b0,
		F_LINE = 1'b1
	} front_state_t;

	typedef enum logic [1:0] {
		B_INIT  = 2'd0,
		B_IDLE  = 2'd1,
		B_WRITE = 2'd2,
		B_CLEAR = 2'd3
	} back_state_t;

	function automatic op_t pixel_op(logic [7:0] x, logic [7:0] y, logic color, logic last);
		op_t         op;
		logic [15:0] lin;
		lin        = 16'(y[7:3]) * 16'(DISPLAY_WIDTH) + 16'(x);
		op.kind    = OP_PIXEL;
		op.hit     = (9'(x) < 9'(DISPLAY_WIDTH)) && (9'(y) < 9'(DISPLAY_HEIGHT));
		op.addr    = lin[ADDR_W-1:0];
		op.bit_sel = y[2:0];
		op.color   = color;
		op.last    = last;
		return op;
	endfunction

	function automatic op_t read_op(logic [2:0] page, logic [6:0] column);
		op_t         op;
		logic [15:0] lin;
		lin        = 16'(page) * 16'(DISPLAY_WIDTH) + 16'(column);
		op.kind    = OP_READ;
		op.hit     = (6'(page) < 6'(PAGE_COUNT)) && (9'(column) < 9'(DISPLAY_WIDTH));
		op.addr    = lin[ADDR_W-1:0];
		op.bit_sel = 3'd0;
		op.color   = 1'b0;
		op.last    = 1'b1;
		return op;
	endfunction

	function automatic op_t clear_op();
		op_t op;
		op         = '0;
		op.kind    = OP_CLEAR;
		op.last    = 1'b1;
		return op;
	endfunction

endpackage

// ===== hw/rtl/fbl_cmd_if.sv =====
// Command channel of the framebuffer line plotter: valid, ready and the command fields.
// No dependencies.
interface fbl_cmd_if;
	logic       valid;
	logic       ready;
	logic [1:0] mode;
	logic [7:0] x_start;
	logic [7:0] y_start;
	logic [7:0] x_end;
	logic [7:0] y_end;
	logic       color;
	logic [2:0] read_page;
	logic [6:0] read_column;

	modport source (
		output valid, mode, x_start, y_start, x_end, y_end, color, read_page, read_column,
		input  ready
	);
	modport sink (
		input  valid, mode, x_start, y_start, x_end, y_end, color, read_page, read_column,
		output ready
	);
endinterface

// ===== hw/rtl/fbl_rsp_if.sv =====
// Result channel of the framebuffer line plotter: valid, ready and the read byte.
// No dependencies.
interface fbl_rsp_if;
	logic       valid;
	logic       ready;
	logic [7:0] read_data;

	modport source (
		output valid, read_data,
		input  ready
	);
	modport sink (
		input  valid, read_data,
		output ready
	);
endinterface

// ===== hw/rtl/fbl_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module fbl_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;
endmodule

// ===== hw/rtl/fbl_queue.sv =====
// Short operation queue between the command front end and the framebuffer back end.
// Depends on fbl_pkg and assert_macros.svh.
`include "assert_macros.svh"
module fbl_queue (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  fbl_pkg::op_t push_op,
	output logic         full,
	input  logic         pop,
	output logic         not_empty,
	output fbl_pkg::op_t head_op
);
	import fbl_pkg::*;

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	op_t              slot_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	always_comb begin
		full      = count_q == CNT_W'(QUEUE_DEPTH);
		not_empty = count_q != '0;
		head_op   = slot_q[rd_ptr_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_op;
		end
	end

	`ASSERT_NEVER(a_no_push_full, clk, arst_n, push && full, "queue pushed while full")
	`ASSERT_NEVER(a_no_pop_empty, clk, arst_n, pop && !not_empty, "queue popped while empty")
endmodule

// ===== hw/rtl/fbl_front.sv =====
// Front end: accepts command beats, classifies them and walks Bresenham lines pixel by pixel.
// Depends on fbl_pkg, fbl_cmd_if and assert_macros.svh.
`include "assert_macros.svh"
module fbl_front (
	input  logic                  clk,
	input  logic                  arst_n,
	fbl_cmd_if.sink               cmd,
	input  fbl_pkg::back_status_t status,
	input  logic                  q_full,
	output logic                  q_push,
	output fbl_pkg::op_t          q_op
);
	import fbl_pkg::*;

	front_state_t             state_q;
	front_state_t             state_d;
	logic [7:0]               xa_q;
	logic [7:0]               ya_q;
	logic [7:0]               xb_q;
	logic [7:0]               yb_q;
	logic signed [ERR_W-1:0]  dx_q;
	logic signed [ERR_W-1:0]  dy_q;
	logic signed [ERR_W-1:0]  err_q;
	logic                     sx_neg_q;
	logic                     sy_neg_q;
	logic                     color_q;

	logic                     accept;
	logic                     line_done;
	logic                     step;
	logic [7:0]               adx;
	logic [7:0]               ady;
	logic signed [ERR_W-1:0]  dx_init;
	logic signed [ERR_W-1:0]  dy_init;
	logic signed [ERR_W:0]    e2;
	logic                     step_x;
	logic                     step_y;
	logic signed [ERR_W-1:0]  err_next;

	always_comb begin
		accept    = cmd.valid && cmd.ready;
		line_done = (xa_q == xb_q) && (ya_q == yb_q);
		step      = (state_q == F_LINE) && !q_full && !line_done;
		adx       = (cmd.x_end > cmd.x_start) ? cmd.x_end - cmd.x_start
		                                      : cmd.x_start - cmd.x_end;
		ady       = (cmd.y_end > cmd.y_start) ? cmd.y_end - cmd.y_start
		                                      : cmd.y_start - cmd.y_end;
		dx_init   = $signed(ERR_W'(adx));
		dy_init   = -$signed(ERR_W'(ady));
		e2        = {err_q, 1'b0};
		step_x    = e2 >= (ERR_W + 1)'(dy_q);
		step_y    = e2 <= (ERR_W + 1)'(dx_q);
		err_next  = err_q + (step_x ? dy_q : '0) + (step_y ? dx_q : '0);
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			F_IDLE: begin
				if (accept && mode_t'(cmd.mode) == MODE_LINE) begin
					state_d = F_LINE;
				end
			end
			F_LINE: begin
				if (!q_full && line_done) begin
					state_d = F_IDLE;
				end
			end
			default: state_d = F_IDLE;
		endcase
	end

	always_comb begin
		cmd.ready = 1'b0;
		q_push    = 1'b0;
		q_op      = pixel_op(xa_q, ya_q, color_q, line_done);
		case (state_q)
			F_IDLE: begin
				cmd.ready = !q_full && !status.init_busy;
				q_push    = accept && mode_t'(cmd.mode) != MODE_LINE;
				case (mode_t'(cmd.mode))
					MODE_PLOT: q_op = pixel_op(cmd.x_start, cmd.y_start, cmd.color, 1'b1);
					MODE_READ: q_op = read_op(cmd.read_page, cmd.read_column);
					MODE_CLEAR: q_op = clear_op();
					default: q_op = pixel_op(cmd.x_start, cmd.y_start, cmd.color, 1'b1);
				endcase
			end
			F_LINE: begin
				q_push = !q_full;
			end
			default: begin
				q_push = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && mode_t'(cmd.mode) == MODE_LINE) begin
			xa_q     <= cmd.x_start;
			ya_q     <= cmd.y_start;
			xb_q     <= cmd.x_end;
			yb_q     <= cmd.y_end;
			dx_q     <= dx_init;
			dy_q     <= dy_init;
			err_q    <= dx_init + dy_init;
			sx_neg_q <= !(cmd.x_start < cmd.x_end);
			sy_neg_q <= !(cmd.y_start < cmd.y_end);
			color_q  <= cmd.color;
		end else if (step) begin
			err_q <= err_next;
			if (step_x) begin
				xa_q <= sx_neg_q ? xa_q - 1'b1 : xa_q + 1'b1;
			end
			if (step_y) begin
				ya_q <= sy_neg_q ? ya_q - 1'b1 : ya_q + 1'b1;
			end
		end
	end

	`ASSERT_PROP(a_line_progress, clk, arst_n, step |=> (xa_q != $past(xa_q) || ya_q != $past(ya_q)), "line walk stalled on one pixel")
	`ASSERT_PROP(a_line_end, clk, arst_n, (state_q == F_LINE && q_push && q_op.last) |=> state_q == F_IDLE, "line end pushed but walk kept going")
endmodule

// ===== hw/rtl/fbl_back.sv =====
// Back end: read-modify-write of framebuffer bytes, byte reads, clearing sweeps and result beats.
// Depends on fbl_pkg, fbl_rsp_if, fbl_ram and assert_macros.svh.
`include "assert_macros.svh"
module fbl_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  q_valid,
	input  fbl_pkg::op_t          q_head,
	output logic                  q_pop,
	output fbl_pkg::back_status_t status,
	fbl_rsp_if.source             rsp
);
	import fbl_pkg::*;

	back_state_t       state_q;
	back_state_t       state_d;
	logic [ADDR_W-1:0] clr_q;
	op_t               op_q;
	logic              out_valid_q;
	logic [7:0]        out_data_q;

	logic              take;
	logic              clr_last;
	logic              load_out;
	logic [7:0]        load_data;
	logic [7:0]        mask;
	logic              ram_we;
	logic [ADDR_W-1:0] ram_waddr;
	logic [7:0]        ram_wdata;
	logic [ADDR_W-1:0] ram_raddr;
	logic [7:0]        ram_rdata;

	fbl_ram #(
		.WIDTH (8),
		.DEPTH (STORE_SIZE)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_comb begin
		take     = (state_q == B_IDLE) && q_valid && !(q_head.last && out_valid_q);
		clr_last = clr_q == ADDR_W'(STORE_SIZE - 1);
		mask     = 8'b1 << op_q.bit_sel;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			B_INIT: begin
				if (clr_last) begin
					state_d = B_IDLE;
				end
			end
			B_IDLE: begin
				if (take) begin
					state_d = (q_head.kind == OP_CLEAR) ? B_CLEAR : B_WRITE;
				end
			end
			B_WRITE: state_d = B_IDLE;
			B_CLEAR: begin
				if (clr_last) begin
					state_d = B_IDLE;
				end
			end
			default: state_d = B_INIT;
		endcase
	end

	always_comb begin
		q_pop            = take;
		status.init_busy = state_q == B_INIT;
		ram_raddr        = q_head.addr;
		ram_we           = 1'b0;
		ram_waddr        = clr_q;
		ram_wdata        = '0;
		load_out         = 1'b0;
		load_data        = '0;
		case (state_q)
			B_INIT: begin
				ram_we = 1'b1;
			end
			B_IDLE: begin
				ram_we = 1'b0;
			end
			B_WRITE: begin
				ram_waddr = op_q.addr;
				ram_we    = (op_q.kind == OP_PIXEL) && op_q.hit;
				ram_wdata = op_q.color ? (ram_rdata | mask) : (ram_rdata & ~mask);
				load_out  = op_q.last;
				load_data = ((op_q.kind == OP_READ) && op_q.hit) ? ram_rdata : '0;
			end
			B_CLEAR: begin
				ram_we   = 1'b1;
				load_out = clr_last;
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_INIT;
			clr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == B_INIT || state_q == B_CLEAR) begin
				clr_q <= clr_last ? '0 : clr_q + 1'b1;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			op_q <= q_head;
		end
		if (load_out) begin
			out_data_q <= load_data;
		end
	end

	assign rsp.valid     = out_valid_q;
	assign rsp.read_data = out_data_q;

	`ASSERT_NEVER(a_no_result_overwrite, clk, arst_n, load_out && out_valid_q, "result overwritten before it was taken")
	`ASSERT_PROP(a_rmw_same_byte, clk, arst_n, (ram_we && state_q == B_WRITE) |-> ram_waddr == $past(ram_raddr), "modify wrote a byte other than the one read")
endmodule

// ===== hw/rtl/framebuffer_line_plotter.sv =====
// Top level of the framebuffer line plotter: front end, operation queue and back end.
// Depends on fbl_pkg, fbl_cmd_if, fbl_rsp_if, fbl_front, fbl_queue and fbl_back.
//
//   Port   Direction  Beat contents
//   cmd    in         mode, x_start, y_start, x_end, y_end, color, read_page, read_column
//   rsp    out        read_data, one beat per command
//
// Every framebuffer byte update is a read, issued as the operation leaves the queue,
// followed by a write in B_WRITE, on the store's separate read and write ports.
// A clear command sweeps all 1024 bytes of the store one byte a cycle.
// After reset the same sweep runs and no command is accepted meanwhile.
// Up to four operations queue between the front and back ends, and a stalled result
// holds only the next command's final operation.
module framebuffer_line_plotter (
	input logic        clk,
	input logic        arst_n,
	fbl_cmd_if.sink    cmd,
	fbl_rsp_if.source  rsp
);
	import fbl_pkg::*;

	back_status_t status;
	logic         q_full;
	logic         q_push;
	op_t          q_op;
	logic         q_pop;
	logic         q_valid;
	op_t          q_head;

	fbl_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.status (status),
		.q_full (q_full),
		.q_push (q_push),
		.q_op   (q_op)
	);

	fbl_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_op   (q_op),
		.full      (q_full),
		.pop       (q_pop),
		.not_empty (q_valid),
		.head_op   (q_head)
	);

	fbl_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (q_valid),
		.q_head  (q_head),
		.q_pop   (q_pop),
		.status  (status),
		.rsp     (rsp)
	);
endmodule
